[src/avp_pkg.sv]
// Shared types and constants for the Art-Net packet validator.
// No dependencies; compiled first.
package avp_pkg;

  localparam int unsigned POS_W     = 10;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned UNIV_W    = 15;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  typedef logic [VERDICT_W-1:0] verdict_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam verdict_t VERDICT_REJECT = 3'd0;
  localparam verdict_t VERDICT_POLL   = 3'd1;
  localparam verdict_t VERDICT_SYNC   = 3'd2;
  localparam verdict_t VERDICT_DMX    = 3'd3;
  localparam verdict_t VERDICT_NZS    = 3'd4;

  localparam cfg_idx_t CFG_MIN_VERSION  = 2'd0;
  localparam cfg_idx_t CFG_BCAST_ENABLE = 2'd1;
  localparam cfg_idx_t CFG_SYNC_TIMEOUT = 2'd2;

  localparam logic [15:0] OPC_POLL   = 16'h2000;
  localparam logic [15:0] OPC_OUTPUT = 16'h5000;
  localparam logic [15:0] OPC_NZS    = 16'h5100;
  localparam logic [15:0] OPC_SYNC   = 16'h5200;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h41;
      3'd1:    val = 8'h72;
      3'd2:    val = 8'h74;
      3'd3:    val = 8'h2D;
      3'd4:    val = 8'h4E;
      3'd5:    val = 8'h65;
      3'd6:    val = 8'h74;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

[src/avp_if.sv]
// Valid/ready stream interfaces for the byte input and the verdict output.
// Depends on avp_pkg.
interface avp_in_if;
  import avp_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        pkt_byte;
  logic              byte_last;
  logic              from_broadcast;
  logic [TIME_W-1:0] time_now;

  modport source (output valid, pkt_byte, byte_last, from_broadcast, time_now,
                  input ready);
  modport sink   (input valid, pkt_byte, byte_last, from_broadcast, time_now,
                  output ready);
endinterface

interface avp_out_if;
  import avp_pkg::*;
  logic              valid;
  logic              ready;
  verdict_t          verdict;
  logic [UNIV_W-1:0] universe_out;
  logic [SLOT_W-1:0] slot_count;
  logic              fire_sync;
  logic              sync_mode_now;

  modport source (output valid, verdict, universe_out, slot_count, fire_sync,
                  sync_mode_now, input ready);
  modport sink   (input valid, verdict, universe_out, slot_count, fire_sync,
                  sync_mode_now, output ready);
endinterface

[src/artnet_packet_validator.sv]
// Art-Net packet validator top level: header capture, checks, sync watchdog.
// Depends on avp_pkg and the interfaces in avp_if.sv.
//
// Takes one packet byte per cycle and issues one verdict transaction per packet
// after the final byte is accepted: an input register, then the header capture
// and decision logic, then the result register. Bytes keep flowing while a
// verdict waits on the output; only a final byte stalls when the result register
// is still full. Packets of 18 up to PACKET_BYTES bytes are judged; MAX_SLOTS
// bounds the accepted slot count. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata while no packet is in flight; nothing enforces it.
module artnet_packet_validator #(
  parameter int unsigned PACKET_BYTES = 530,
  parameter int unsigned MAX_SLOTS    = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  avp_in_if.sink                     in_ch,
  avp_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  avp_pkg::cfg_idx_t          cfg_index,
  input  logic [avp_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import avp_pkg::*;

  localparam logic [POS_W-1:0] POS_LIM    = PACKET_BYTES[POS_W-1:0];
  localparam logic [15:0]      SLOT_LIM   = MAX_SLOTS[15:0];
  localparam logic [POS_W-1:0] POS_OP_LO  = 10'd8;
  localparam logic [POS_W-1:0] POS_OP_HI  = 10'd9;
  localparam logic [POS_W-1:0] POS_VER_HI = 10'd10;
  localparam logic [POS_W-1:0] POS_VER_LO = 10'd11;
  localparam logic [POS_W-1:0] POS_START  = 10'd13;
  localparam logic [POS_W-1:0] POS_UNI_LO = 10'd14;
  localparam logic [POS_W-1:0] POS_UNI_HI = 10'd15;
  localparam logic [POS_W-1:0] POS_LEN_HI = 10'd16;
  localparam logic [POS_W-1:0] POS_LEN_LO = 10'd17;

  // configuration
  logic [15:0]       min_version_r;
  logic              bcast_en_r;
  logic [TIME_W-1:0] sync_timeout_r;

  // input register
  logic              s0_valid_r;
  logic [7:0]        s0_byte_r;
  logic              s0_last_r;
  logic              s0_bcast_r;
  logic [TIME_W-1:0] s0_time_r;

  // packet capture
  logic [POS_W-1:0]  byte_pos_r;
  logic              too_long_r, too_long_nxt;
  logic              sig_ok_r, sig_ok_nxt;
  logic [15:0]       op_r, op_nxt;
  logic [15:0]       ver_r, ver_nxt;
  logic [15:0]       uni_r, uni_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [7:0]        start_r, start_nxt;

  // persistent sync state
  logic              sync_mode_r, sync_mode_nxt;
  logic [TIME_W-1:0] fed_time_r, fed_time_nxt;

  // result register
  logic              out_valid_r;
  verdict_t          verdict_r, verdict_nxt;
  logic [UNIV_W-1:0] uni_out_r, uni_out_nxt;
  logic [SLOT_W-1:0] slots_r, slots_nxt;
  logic              fire_r, fire_nxt;
  logic              mode_out_r;

  logic              s1_go;
  logic              ok, refuse, good, starved;
  logic [TIME_W-1:0] elapsed;

  assign s1_go       = s0_valid_r && (!s0_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || s1_go;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.verdict       = verdict_r;
  assign out_ch.universe_out  = uni_out_r;
  assign out_ch.slot_count    = slots_r;
  assign out_ch.fire_sync     = fire_r;
  assign out_ch.sync_mode_now = mode_out_r;

  always_comb begin
    op_nxt    = op_r;
    ver_nxt   = ver_r;
    uni_nxt   = uni_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    case (byte_pos_r)
      POS_OP_LO:  op_nxt[7:0]   = s0_byte_r;
      POS_OP_HI:  op_nxt[15:8]  = s0_byte_r;
      POS_VER_HI: ver_nxt[15:8] = s0_byte_r;
      POS_VER_LO: ver_nxt[7:0]  = s0_byte_r;
      POS_START:  start_nxt     = s0_byte_r;
      POS_UNI_LO: uni_nxt[7:0]  = s0_byte_r;
      POS_UNI_HI: uni_nxt[15:8] = s0_byte_r;
      POS_LEN_HI: len_nxt[15:8] = s0_byte_r;
      POS_LEN_LO: len_nxt[7:0]  = s0_byte_r;
      default: ;
    endcase
    sig_ok_nxt   = sig_ok_r &&
                   ((byte_pos_r >= POS_OP_LO) || (s0_byte_r == sig_byte(byte_pos_r[2:0])));
    too_long_nxt = too_long_r || (byte_pos_r >= POS_LIM);

    ok = (byte_pos_r >= POS_LEN_LO) && !too_long_nxt && sig_ok_nxt &&
         (ver_nxt >= min_version_r);
    refuse = s0_bcast_r && !bcast_en_r;
    good = !refuse && (len_nxt >= 16'd2) && (len_nxt <= SLOT_LIM) && !len_nxt[0] &&
           !uni_nxt[15] && !((op_nxt == OPC_NZS) && (start_nxt != 8'd0));

    elapsed = s0_time_r - fed_time_r;
    starved = (fed_time_r == '0) || (elapsed > sync_timeout_r);

    verdict_nxt   = VERDICT_REJECT;
    uni_out_nxt   = '0;
    slots_nxt     = '0;
    fire_nxt      = 1'b0;
    sync_mode_nxt = sync_mode_r;
    fed_time_nxt  = fed_time_r;
    if (ok) begin
      if (op_nxt == OPC_POLL) begin
        verdict_nxt = VERDICT_POLL;
      end else if (op_nxt == OPC_SYNC) begin
        if (!refuse) begin
          verdict_nxt   = VERDICT_SYNC;
          sync_mode_nxt = 1'b1;
          fire_nxt      = 1'b1;
          fed_time_nxt  = s0_time_r;
        end
      end else if ((op_nxt == OPC_OUTPUT) || (op_nxt == OPC_NZS)) begin
        if (good) begin
          verdict_nxt = (op_nxt == OPC_NZS) ? VERDICT_NZS : VERDICT_DMX;
          uni_out_nxt = uni_nxt[UNIV_W-1:0];
          slots_nxt   = len_nxt[SLOT_W-1:0];
          if (sync_mode_r && starved) begin
            fire_nxt      = 1'b1;
            sync_mode_nxt = 1'b0;
            fed_time_nxt  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_version_r  <= 16'd14;
      bcast_en_r     <= 1'b1;
      sync_timeout_r <= 32'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_VERSION:  min_version_r  <= cfg_wdata[15:0];
        CFG_BCAST_ENABLE: bcast_en_r     <= cfg_wdata[0];
        CFG_SYNC_TIMEOUT: sync_timeout_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s0_byte_r  <= in_ch.pkt_byte;
      s0_last_r  <= in_ch.byte_last;
      s0_bcast_r <= in_ch.from_broadcast;
      s0_time_r  <= in_ch.time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      too_long_r  <= 1'b0;
      sig_ok_r    <= 1'b1;
      op_r        <= '0;
      ver_r       <= '0;
      uni_r       <= '0;
      len_r       <= '0;
      start_r     <= '0;
      sync_mode_r <= 1'b0;
      fed_time_r  <= '0;
    end else if (s1_go) begin
      if (s0_last_r) begin
        byte_pos_r  <= '0;
        too_long_r  <= 1'b0;
        sig_ok_r    <= 1'b1;
        op_r        <= '0;
        ver_r       <= '0;
        uni_r       <= '0;
        len_r       <= '0;
        start_r     <= '0;
        sync_mode_r <= sync_mode_nxt;
        fed_time_r  <= fed_time_nxt;
      end else begin
        if (byte_pos_r != '1) begin
          byte_pos_r <= byte_pos_r + 10'd1;
        end
        too_long_r <= too_long_nxt;
        sig_ok_r   <= sig_ok_nxt;
        op_r       <= op_nxt;
        ver_r      <= ver_nxt;
        uni_r      <= uni_nxt;
        len_r      <= len_nxt;
        start_r    <= start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s0_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && s0_last_r) begin
      verdict_r  <= verdict_nxt;
      uni_out_r  <= uni_out_nxt;
      slots_r    <= slots_nxt;
      fire_r     <= fire_nxt;
      mode_out_r <= sync_mode_nxt;
    end
  end

endmodule

[src/avp_checker.sv]
// Port-level checks for artnet_packet_validator, attached with bind.
// Depends on avp_pkg.
module avp_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input avp_pkg::verdict_t       verdict,
  input logic [avp_pkg::UNIV_W-1:0] universe_out,
  input logic [avp_pkg::SLOT_W-1:0] slot_count,
  input logic                    fire_sync,
  input logic                    sync_mode_now
);
  import avp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(slot_count))
    else $error("result changed while stalled");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (verdict == VERDICT_REJECT || verdict == VERDICT_POLL) |->
      universe_out == '0 && slot_count == '0 && !fire_sync)
    else $error("reject/poll transaction carries data or sync");

  a_sync_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict == VERDICT_SYNC |-> fire_sync && sync_mode_now &&
      universe_out == '0 && slot_count == '0)
    else $error("sync transaction without fire and sync mode");

  a_output_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (verdict == VERDICT_DMX || verdict == VERDICT_NZS) |->
      !slot_count[0] && slot_count != '0)
    else $error("accepted output with bad slot count");

  a_fire_leaves_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fire_sync && (verdict == VERDICT_DMX || verdict == VERDICT_NZS) |->
      !sync_mode_now)
    else $error("watchdog sync did not leave sync mode");

endmodule

bind artnet_packet_validator avp_checker u_avp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .verdict       (out_ch.verdict),
  .universe_out  (out_ch.universe_out),
  .slot_count    (out_ch.slot_count),
  .fire_sync     (out_ch.fire_sync),
  .sync_mode_now (out_ch.sync_mode_now)
);

[test/artnet_packet_validator_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for artnet_packet_validator: directed and random packet
// streams against a cycle-free verdict predictor. Depends on avp_pkg and avp_if.sv.
module artnet_packet_validator_tb;
  import avp_pkg::*;

  localparam int unsigned PKT_MAX     = 530;
  localparam int unsigned SLOT_MAX    = 512;
  localparam int unsigned HDR_LEN     = 18;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [63:0] ART_SIG     = 64'h41_72_74_2D_4E_65_74_00;

  typedef struct packed {
    verdict_t          verdict;
    logic [UNIV_W-1:0] universe;
    logic [SLOT_W-1:0] slots;
    logic              fire;
    logic              mode;
  } verdict_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  avp_in_if  in_ch ();
  avp_out_if out_ch ();

  artnet_packet_validator #(
    .PACKET_BYTES(PKT_MAX),
    .MAX_SLOTS   (SLOT_MAX)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor copy of configuration and header capture
  logic [15:0] cfg_min_ver;
  logic        cfg_bcast_en;
  logic [31:0] cfg_sync_tmo;
  logic [9:0]  cap_pos;
  logic        cap_overrun;
  logic        cap_sig_good;
  logic [15:0] cap_opcode;
  logic [15:0] cap_version;
  logic [15:0] cap_universe;
  logic [15:0] cap_length;
  logic [7:0]  cap_start;
  logic        sync_on;
  logic [31:0] last_feed;

  verdict_rec_t pending_verdicts[$];
  logic [7:0]   pkt_buf[$];
  logic [31:0]  wall_time;
  int           errors = 0;
  int           cycles = 0;
  bit           src_gap_en;
  bit           sink_stall_en;
  int           sink_hold = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic clear_capture();
    cap_pos      = '0;
    cap_overrun  = 1'b0;
    cap_sig_good = 1'b1;
    cap_opcode   = '0;
    cap_version  = '0;
    cap_universe = '0;
    cap_length   = '0;
    cap_start    = '0;
  endtask

  // header capture per byte; verdict at the final byte
  task automatic track_header_byte(input logic [7:0] b, input logic last, input logic bcast,
                                   input logic [31:0] now);
    logic [9:0]   pos;
    verdict_rec_t rec;
    logic         ok;
    logic         refuse;
    logic         good;
    pos = cap_pos;
    if (pos < 8) begin
      if (b != ART_SIG[63 - 8*pos -: 8]) cap_sig_good = 1'b0;
    end else begin
      case (pos)
        10'd8:   cap_opcode[7:0]    = b;
        10'd9:   cap_opcode[15:8]   = b;
        10'd10:  cap_version[15:8]  = b;
        10'd11:  cap_version[7:0]   = b;
        10'd13:  cap_start          = b;
        10'd14:  cap_universe[7:0]  = b;
        10'd15:  cap_universe[15:8] = b;
        10'd16:  cap_length[15:8]   = b;
        10'd17:  cap_length[7:0]    = b;
        default: ;
      endcase
    end
    if (pos >= PKT_MAX) cap_overrun = 1'b1;
    if (pos < 10'd1023) cap_pos = pos + 10'd1;
    if (last) begin
      rec    = '{VERDICT_REJECT, '0, '0, 1'b0, 1'b0};
      ok     = (int'(pos) + 1 >= HDR_LEN) && !cap_overrun && cap_sig_good &&
               (cap_version >= cfg_min_ver);
      refuse = bcast && !cfg_bcast_en;
      if (ok) begin
        if (cap_opcode == OPC_POLL) begin
          rec.verdict = VERDICT_POLL;
        end else if (cap_opcode == OPC_SYNC) begin
          if (!refuse) begin
            rec.verdict = VERDICT_SYNC;
            rec.fire    = 1'b1;
            sync_on     = 1'b1;
            last_feed   = now;
          end
        end else if (cap_opcode == OPC_OUTPUT || cap_opcode == OPC_NZS) begin
          good = !refuse && cap_length >= 16'd2 && cap_length <= SLOT_MAX &&
                 !cap_length[0] && !cap_universe[15];
          if (cap_opcode == OPC_NZS && cap_start != 8'h00) good = 1'b0;
          if (good) begin
            rec.verdict  = (cap_opcode == OPC_NZS) ? VERDICT_NZS : VERDICT_DMX;
            rec.universe = cap_universe[14:0];
            rec.slots    = cap_length[9:0];
            if (sync_on && (last_feed == 32'd0 || (now - last_feed) > cfg_sync_tmo)) begin
              last_feed = 32'd0;
              rec.fire  = 1'b1;
              sync_on   = 1'b0;
            end
          end
        end
      end
      rec.mode = sync_on;
      pending_verdicts.push_back(rec);
      clear_capture();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic bcast,
                           input logic [31:0] now);
    if (src_gap_en && $urandom_range(2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pkt_byte       <= b;
    in_ch.byte_last      <= last;
    in_ch.from_broadcast <= bcast;
    in_ch.time_now       <= now;
    do @(posedge clk); while (!in_ch.ready);
    track_header_byte(b, last, bcast, now);
  endtask

  task automatic send_packet(input logic bcast, input logic [31:0] now);
    int n;
    n = pkt_buf.size();
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_byte(pkt_buf[i], 1'b1, bcast, now);
      else send_byte(pkt_buf[i], 1'b0, 1'($urandom_range(1)), $urandom());
    end
  endtask

  task automatic build_packet(input logic [15:0] op, input logic [15:0] ver,
                              input logic [7:0] sc, input logic [15:0] uni,
                              input logic [15:0] len, input int total);
    logic [7:0] b;
    pkt_buf.delete();
    for (int i = 0; i < total; i++) begin
      if (i < 8) begin
        b = ART_SIG[63 - 8*i -: 8];
      end else begin
        case (i)
          8:       b = op[7:0];
          9:       b = op[15:8];
          10:      b = ver[15:8];
          11:      b = ver[7:0];
          13:      b = sc;
          14:      b = uni[7:0];
          15:      b = uni[15:8];
          16:      b = len[15:8];
          17:      b = len[7:0];
          default: b = 8'($urandom());
        endcase
      end
      pkt_buf.push_back(b);
    end
  endtask

  task automatic send_artnet(input logic [15:0] op, input logic [15:0] ver,
                             input logic [7:0] sc, input logic [15:0] uni,
                             input logic [15:0] len, input int total,
                             input logic bcast, input logic [31:0] now);
    build_packet(op, ver, sc, uni, len, total);
    send_packet(bcast, now);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] minv, input logic ben,
                              input logic [31:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_VERSION;
    cfg_wdata <= {16'($urandom()), minv};
    @(posedge clk);
    cfg_min_ver = minv;
    cfg_index <= CFG_BCAST_ENABLE;
    cfg_wdata <= {31'($urandom()), ben};
    @(posedge clk);
    cfg_bcast_en = ben;
    cfg_index <= CFG_SYNC_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_sync_tmo = tmo;
    cfg_we <= 1'b0;
  endtask

  // verdict transaction checker and sink-side stalls
  always @(posedge clk) begin : verdict_check
    verdict_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: expected none actual verdict %0d", $time,
                 out_ch.verdict);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(out_ch.verdict));
        check_field("universe_out", 32'(want.universe), 32'(out_ch.universe_out));
        check_field("slot_count", 32'(want.slots), 32'(out_ch.slot_count));
        check_field("fire_sync", 32'(want.fire), 32'(out_ch.fire_sync));
        check_field("sync_mode_now", 32'(want.mode), 32'(out_ch.sync_mode_now));
      end
    end
    if (sink_hold > 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_stall_en && $urandom_range(3) == 0) sink_hold = pick_gap();
    end
  end

  task automatic test_header_fields();
    send_artnet(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd5);
    send_artnet(OPC_POLL, 16'd13, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd6);
    send_artnet(OPC_POLL, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 18, 1'b1, 32'hFFFF_FFFF);
    send_artnet(16'h2100, 16'd14, 8'h00, 16'h0001, 16'd2, 18, 1'b0, 32'd7);
    send_artnet(16'h0050, 16'd14, 8'h00, 16'h0001, 16'd2, 18, 1'b0, 32'd8);
    build_packet(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000, 18);
    pkt_buf[7] = 8'h20;
    send_packet(1'b0, 32'd9);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0000, 16'd3, 18, 1'b0, 32'd10);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0000, 16'd0, 18, 1'b0, 32'd11);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0000, 16'd514, 18, 1'b0, 32'd12);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h8000, 16'd2, 18, 1'b0, 32'd13);
    send_artnet(OPC_NZS, 16'd14, 8'h01, 16'h0005, 16'd2, 18, 1'b0, 32'd14);
    send_artnet(OPC_OUTPUT, 16'd14, 8'hAA, 16'h7FFF, 16'd512, 20, 1'b1, 32'd15);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0000, 16'd2, 18, 1'b0, 32'd16);
    send_artnet(OPC_NZS, 16'd14, 8'h00, 16'h1234, 16'd2, 18, 1'b0, 32'd17);
  endtask

  task automatic test_sync_watchdog();
    send_artnet(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd100);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0001, 16'd4, 18, 1'b0, 32'd1100);
    send_artnet(OPC_NZS, 16'd14, 8'h00, 16'h0001, 16'd4, 18, 1'b0, 32'd1101);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0001, 16'd4, 18, 1'b0, 32'd1200);
    send_artnet(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd0);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0002, 16'd6, 18, 1'b0, 32'd5);
    send_artnet(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'hFFFF_FF00);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0003, 16'd8, 18, 1'b0, 32'h0000_0010);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0003, 16'd9, 18, 1'b0, 32'd5000);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0003, 16'd8, 18, 1'b0, 32'd5000);
  endtask

  task automatic test_packet_lengths();
    send_artnet(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000, 1, 1'b0, 32'd20);
    send_artnet(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000, 17, 1'b0, 32'd21);
    send_artnet(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000, PKT_MAX, 1'b0, 32'd22);
    send_artnet(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000, PKT_MAX + 1, 1'b0, 32'd23);
    send_artnet(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd25);
  endtask

  task automatic test_config_settings();
    wait_idle();
    apply_config(16'd14, 1'b0, 32'd1000);
    send_artnet(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b1, 32'd300);
    send_artnet(OPC_POLL, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b1, 32'd301);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0010, 16'd2, 18, 1'b1, 32'd302);
    send_artnet(OPC_OUTPUT, 16'd14, 8'h00, 16'h0010, 16'd2, 18, 1'b0, 32'd303);
    send_artnet(OPC_SYNC, 16'd14, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd304);
    wait_idle();
    apply_config(16'd0, 1'b1, 32'd0);
    send_artnet(OPC_POLL, 16'd0, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd5);
    send_artnet(OPC_SYNC, 16'd0, 8'h00, 16'h0000, 16'h0000, 18, 1'b1, 32'd10);
    send_artnet(OPC_OUTPUT, 16'd0, 8'h00, 16'h0020, 16'd2, 18, 1'b1, 32'd10);
    send_artnet(OPC_OUTPUT, 16'd0, 8'h00, 16'h0020, 16'd2, 18, 1'b0, 32'd11);
    wait_idle();
    apply_config(16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_artnet(OPC_POLL, 16'hFFFE, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd1);
    send_artnet(OPC_SYNC, 16'hFFFF, 8'h00, 16'h0000, 16'h0000, 18, 1'b0, 32'd1);
    send_artnet(OPC_NZS, 16'hFFFF, 8'h00, 16'h7FFF, 16'd512, 18, 1'b0, 32'd0);
    wait_idle();
    apply_config(16'd14, 1'b1, 32'd1000);
  endtask

  task automatic send_random_packet();
    int          r;
    int          total;
    logic [15:0] op;
    logic [15:0] ver;
    logic [16:0] ver_up;
    logic [15:0] uni;
    logic [15:0] len;
    logic [7:0]  sc;
    logic        bc;
    r = $urandom_range(9);
    if (r < 2) op = OPC_POLL;
    else if (r < 4) op = OPC_SYNC;
    else if (r < 7) op = OPC_OUTPUT;
    else if (r < 9) op = OPC_NZS;
    else op = 16'($urandom());
    r = $urandom_range(99);
    ver_up = {1'b0, cfg_min_ver} + 17'($urandom_range(3));
    if (r < 85) ver = ver_up[16] ? 16'hFFFF : ver_up[15:0];
    else if (r < 95 && cfg_min_ver != 16'd0) ver = cfg_min_ver - 16'd1;
    else ver = 16'($urandom());
    sc  = ($urandom_range(4) == 0) ? 8'($urandom()) : 8'h00;
    uni = ($urandom_range(6) == 0) ? (16'h8000 | 16'($urandom())) : 16'($urandom_range(32767));
    len = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'(2 * $urandom_range(1, 256));
    if ($urandom_range(7) == 0) len = 16'($urandom_range(1023));
    r = $urandom_range(99);
    if (r < 88) total = $urandom_range(18, 21);
    else if (r < 94) total = $urandom_range(1, 17);
    else total = $urandom_range(22, 60);
    build_packet(op, ver, sc, uni, len, total);
    r = $urandom_range(99);
    if (r < 6) begin
      pkt_buf.delete();
      repeat ($urandom_range(1, 30)) pkt_buf.push_back(8'($urandom()));
    end else if (r < 12 && pkt_buf.size() > 7) begin
      pkt_buf[$urandom_range(7)] ^= 8'($urandom_range(1, 255));
    end
    r = $urandom_range(9);
    if (r < 4) wall_time += 32'($urandom_range(600));
    else if (r < 7) wall_time += 32'($urandom_range(990, 1010));
    else if (r < 9) wall_time += cfg_sync_tmo + 32'($urandom_range(2)) - 32'd1;
    else wall_time = $urandom();
    bc = ($urandom_range(9) < 3);
    send_packet(bc, wall_time);
  endtask

  task automatic test_random_traffic();
    int          phase_pkts;
    logic [15:0] minv;
    logic [31:0] tmo;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case ($urandom_range(4))
        0:       minv = 16'd0;
        1:       minv = 16'd14;
        2:       minv = 16'hFFFF;
        default: minv = 16'($urandom_range(40));
      endcase
      case ($urandom_range(4))
        0:       tmo = 32'd0;
        1:       tmo = 32'd1000;
        2:       tmo = 32'hFFFF_FFFF;
        default: tmo = 32'($urandom_range(1, 5000));
      endcase
      apply_config(minv, 1'($urandom_range(1)), tmo);
      src_gap_en    = (ph % 4) < 2;
      sink_stall_en = (ph % 2) == 0;
      phase_pkts    = 0;
      while (phase_pkts < 5) begin
        send_random_packet();
        phase_pkts++;
      end
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.pkt_byte       <= 8'h00;
    in_ch.byte_last      <= 1'b0;
    in_ch.from_broadcast <= 1'b0;
    in_ch.time_now       <= 32'd0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_MIN_VERSION;
    cfg_wdata            <= '0;
    cfg_min_ver          = 16'd14;
    cfg_bcast_en         = 1'b1;
    cfg_sync_tmo         = 32'd1000;
    sync_on              = 1'b0;
    last_feed            = 32'd0;
    wall_time            = 32'd2000;
    src_gap_en           = 1'b1;
    sink_stall_en        = 1'b1;
    clear_capture();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_fields();
    test_sync_watchdog();
    test_packet_lengths();
    test_config_settings();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
